// ----- rtl/ledt_pkg.sv -----
`default_nettype none

package ledt_pkg;

  // line store geometry
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned RowW     = 16;
  localparam int unsigned OutColW  = 11;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned ThrW     = 8;

  // pixel and luma
  localparam int unsigned PixW     = 8;
  localparam int unsigned LumaAccW = 25;
  localparam logic [LumaAccW-1:0] LumaR     = LumaAccW'(19595);
  localparam logic [LumaAccW-1:0] LumaG     = LumaAccW'(38470);
  localparam logic [LumaAccW-1:0] LumaB     = LumaAccW'(7471);
  localparam logic [LumaAccW-1:0] LumaRound = LumaAccW'(32768);
  localparam int unsigned LumaShift = 16;

  // result buffering
  localparam int unsigned MaxRes     = 4;
  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = FifoPtrW + 1;
  localparam int unsigned StallLevel = FifoDepth - 2 * MaxRes;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth    = 2'd0,
    CfgImageHeight   = 2'd1,
    CfgEdgeThreshold = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [OutColW-1:0] out_col;
    logic [RowW-1:0]    out_row;
    logic               edge_res;
    logic               last_of_run;
  } res_t;

  // position and border flags of the pixel in the window stage
  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            xge1;
    logic            xge2;
    logic            yge1;
    logic            yge2;
    logic            xlast;
    logic            ylast;
  } ctrl_t;

  // up to four results of one pixel, in emission order
  typedef struct packed {
    logic [MaxRes-1:0] vld;
    res_t [MaxRes-1:0] res;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/laplacian_edge_threshold_top.sv -----
// Laplacian edge marker for a raster RGB pixel stream: each pixel becomes an
// 8-bit luma, the 3x3 cross Laplacian (replicated border) is clamped to 0..255
// and compared with edge_threshold. Results lag one row and one column and
// carry their own column and row; the last row comes out together with the
// row before it, and last_of_run flags the final word caused by a pixel. A
// pixel is taken every clock while in_stall_o is low: its luma is formed and both
// row stores are read on accept, and in the next cycle the window stage writes the
// stores back and pushes up to four results into a 16-word result queue drained one
// word per clock while out_stall_i is low. The input stalls while more than 8 words
// are queued, so the rate is one pixel per clock in ordinary rows, while on the last
// row of a frame the one-word-per-clock output holds the input back. The user must
// write geometry only while the block is idle; the block does not enforce it. Writing
// width or height restarts the frame. Configuration writes are always ready.
`default_nettype none

module laplacian_edge_threshold_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ledt_pkg::pix_t                   in_word_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ledt_pkg::res_t                   out_word_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ledt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ledt_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [ledt_pkg::WidthW-1:0] width_q;
  logic [ledt_pkg::RowW-1:0]   height_q;
  logic [ledt_pkg::ThrW-1:0]   thr_q;
  logic [ledt_pkg::ColW-1:0]   col_q, col_d;
  logic [ledt_pkg::RowW-1:0]   row_q, row_d;
  logic [ledt_pkg::ColW-1:0]   wm1;
  logic [ledt_pkg::RowW-1:0]   hm1;
  logic                        accept;
  logic                        cfg_we;
  logic                        geom_we;
  logic                        level_high;
  ledt_pkg::ctrl_t             ctrl_d, ctrl_q;
  logic                        s1_valid_q;
  logic [ledt_pkg::PixW-1:0]   luma_d, luma_q;
  logic [ledt_pkg::LumaAccW-1:0] luma_acc;
  logic [ledt_pkg::PixW-1:0]   older_rd, newer_rd;
  ledt_pkg::push_t             push;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign geom_we     = cfg_we & (cfg_index_i inside {ledt_pkg::CfgImageWidth,
                                                     ledt_pkg::CfgImageHeight});
  assign in_stall_o  = level_high;
  assign accept      = in_valid_i & ~in_stall_o;

  // effective last column and last row
  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > ledt_pkg::MaxWidth) begin
      wm1 = ledt_pkg::ColW'(ledt_pkg::MaxWidth - 1);
    end else begin
      wm1 = ledt_pkg::ColW'(width_q - ledt_pkg::WidthW'(1));
    end
    hm1 = (height_q == '0) ? '0 : height_q - ledt_pkg::RowW'(1);
  end

  // raster position of the next pixel; a geometry write restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == wm1) begin
        col_d = '0;
        row_d = (row_q == hm1) ? '0 : row_q + ledt_pkg::RowW'(1);
      end else begin
        col_d = col_q + ledt_pkg::ColW'(1);
      end
    end
    if (geom_we) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ledt_pkg::WidthW'(640);
      height_q <= ledt_pkg::RowW'(480);
      thr_q    <= ledt_pkg::ThrW'(128);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we) begin
        case (ledt_pkg::cfg_idx_e'(cfg_index_i))
          ledt_pkg::CfgImageWidth: begin
            width_q <= cfg_data_i[ledt_pkg::WidthW-1:0];
          end
          ledt_pkg::CfgImageHeight: begin
            height_q <= cfg_data_i;
          end
          ledt_pkg::CfgEdgeThreshold: begin
            thr_q <= cfg_data_i[ledt_pkg::ThrW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // luma with q0.16 weights, rounded
  assign luma_acc = ledt_pkg::LumaAccW'(in_word_i.red)   * ledt_pkg::LumaR
                  + ledt_pkg::LumaAccW'(in_word_i.green) * ledt_pkg::LumaG
                  + ledt_pkg::LumaAccW'(in_word_i.blue)  * ledt_pkg::LumaB
                  + ledt_pkg::LumaRound;
  assign luma_d   = luma_acc[ledt_pkg::LumaShift +: ledt_pkg::PixW];

  // border flags for the window stage
  always_comb begin
    ctrl_d.x     = col_q;
    ctrl_d.y     = row_q;
    ctrl_d.xge1  = col_q != '0;
    ctrl_d.xge2  = col_q > ledt_pkg::ColW'(1);
    ctrl_d.yge1  = row_q != '0;
    ctrl_d.yge2  = row_q > ledt_pkg::RowW'(1);
    ctrl_d.xlast = col_q == wm1;
    ctrl_d.ylast = row_q == hm1;
  end

  // window stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_d;
      luma_q <= luma_d;
    end
  end

  ledt_line_mem u_line_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (col_q),
    .wr_en_i    (s1_valid_q),
    .wr_addr_i  (ctrl_q.x),
    .wr_older_i (newer_rd),
    .wr_newer_i (luma_q),
    .older_o    (older_rd),
    .newer_o    (newer_rd)
  );

  ledt_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .ctrl_i      (ctrl_q),
    .luma_i      (luma_q),
    .older_i     (older_rd),
    .newer_i     (newer_rd),
    .threshold_i (thr_q),
    .push_o      (push)
  );

  ledt_res_fifo u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .level_high_o (level_high),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

// ----- rtl/ledt_line_mem.sv -----
`default_nettype none

module ledt_line_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [ledt_pkg::ColW-1:0]    rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [ledt_pkg::ColW-1:0]    wr_addr_i,
  input  logic [ledt_pkg::PixW-1:0]    wr_older_i,
  input  logic [ledt_pkg::PixW-1:0]    wr_newer_i,
  output logic [ledt_pkg::PixW-1:0]    older_o,
  output logic [ledt_pkg::PixW-1:0]    newer_o
);

  logic [ledt_pkg::PixW-1:0] older_mem [ledt_pkg::MaxWidth];
  logic [ledt_pkg::PixW-1:0] newer_mem [ledt_pkg::MaxWidth];
  logic [ledt_pkg::PixW-1:0] older_rd_q;
  logic [ledt_pkg::PixW-1:0] newer_rd_q;
  logic [ledt_pkg::PixW-1:0] fwd_older_q;
  logic [ledt_pkg::PixW-1:0] fwd_newer_q;
  logic                      fwd_q;
  logic                      fwd_d;

  // two row stores, read-first, one write and one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
      newer_mem[wr_addr_i] <= wr_newer_i;
    end
    if (rd_en_i) begin
      older_rd_q <= older_mem[rd_addr_i];
      newer_rd_q <= newer_mem[rd_addr_i];
    end
  end

  // same entry written while read: bypass the stale read word
  assign fwd_d = rd_en_i & wr_en_i & (rd_addr_i == wr_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_older_q <= wr_older_i;
      fwd_newer_q <= wr_newer_i;
    end
  end

  assign older_o = fwd_q ? fwd_older_q : older_rd_q;
  assign newer_o = fwd_q ? fwd_newer_q : newer_rd_q;

endmodule

`default_nettype wire

// ----- rtl/ledt_kernel.sv -----
`default_nettype none

module ledt_kernel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s1_valid_i,
  input  ledt_pkg::ctrl_t              ctrl_i,
  input  logic [ledt_pkg::PixW-1:0]    luma_i,
  input  logic [ledt_pkg::PixW-1:0]    older_i,
  input  logic [ledt_pkg::PixW-1:0]    newer_i,
  input  logic [ledt_pkg::ThrW-1:0]    threshold_i,
  output ledt_pkg::push_t              push_o
);

  localparam int unsigned SumW = ledt_pkg::PixW + 4;

  logic [ledt_pkg::PixW-1:0] win_q [3][2];
  logic [ledt_pkg::PixW-1:0] blk   [3][3];
  logic                      edge_a, edge_b, edge_c, edge_d;
  logic [ledt_pkg::ColW-1:0] col_prev;
  logic [ledt_pkg::RowW-1:0] row_prev;

  // clamped cross laplacian compared against the threshold
  function automatic logic edge_of(
    input logic [ledt_pkg::PixW-1:0] c,
    input logic [ledt_pkg::PixW-1:0] l,
    input logic [ledt_pkg::PixW-1:0] r,
    input logic [ledt_pkg::PixW-1:0] u,
    input logic [ledt_pkg::PixW-1:0] d,
    input logic [ledt_pkg::ThrW-1:0] thr
  );
    logic signed [SumW-1:0]    s;
    logic [ledt_pkg::PixW-1:0] v;
    s = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, l}) - $signed({4'b0000, r})
      - $signed({4'b0000, u}) - $signed({4'b0000, d});
    if (s < 0) begin
      v = '0;
    end else if (s > $signed(SumW'(255))) begin
      v = '1;
    end else begin
      v = s[ledt_pkg::PixW-1:0];
    end
    return v > thr;
  endfunction

  // 3x3 block: rows y-2..y, columns x-2..x
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      blk[i][0] = win_q[i][0];
      blk[i][1] = win_q[i][1];
    end
    blk[0][2] = older_i;
    blk[1][2] = newer_i;
    blk[2][2] = luma_i;
  end

  // window shift, once per pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (s1_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= blk[i][1];
        win_q[i][1] <= blk[i][2];
      end
    end
  end

  // four candidate centres, neighbours replicated at the frame border
  always_comb begin
    // column x-1, row y-1
    edge_a = edge_of(blk[1][1],
                     ctrl_i.xge2 ? blk[1][0] : blk[1][1],
                     blk[1][2],
                     ctrl_i.yge2 ? blk[0][1] : blk[1][1],
                     blk[2][1], threshold_i);
    // column x-1, row y (last row)
    edge_b = edge_of(blk[2][1],
                     ctrl_i.xge2 ? blk[2][0] : blk[2][1],
                     blk[2][2],
                     ctrl_i.yge1 ? blk[1][1] : blk[2][1],
                     blk[2][1], threshold_i);
    // column x (last column), row y-1
    edge_c = edge_of(blk[1][2],
                     ctrl_i.xge1 ? blk[1][1] : blk[1][2],
                     blk[1][2],
                     ctrl_i.yge2 ? blk[0][2] : blk[1][2],
                     blk[2][2], threshold_i);
    // column x, row y (last column of last row)
    edge_d = edge_of(blk[2][2],
                     ctrl_i.xge1 ? blk[2][1] : blk[2][2],
                     blk[2][2],
                     ctrl_i.yge1 ? blk[1][2] : blk[2][2],
                     blk[2][2], threshold_i);
  end

  assign col_prev = ctrl_i.x - ledt_pkg::ColW'(1);
  assign row_prev = ctrl_i.y - ledt_pkg::RowW'(1);

  // results in ascending column, then ascending row
  always_comb begin
    push_o.vld[0] = s1_valid_i & ctrl_i.xge1  & ctrl_i.yge1;
    push_o.vld[1] = s1_valid_i & ctrl_i.xge1  & ctrl_i.ylast;
    push_o.vld[2] = s1_valid_i & ctrl_i.xlast & ctrl_i.yge1;
    push_o.vld[3] = s1_valid_i & ctrl_i.xlast & ctrl_i.ylast;

    push_o.res[0].out_col  = ledt_pkg::OutColW'(col_prev);
    push_o.res[0].out_row  = row_prev;
    push_o.res[0].edge_res = edge_a;
    push_o.res[1].out_col  = ledt_pkg::OutColW'(col_prev);
    push_o.res[1].out_row  = ctrl_i.y;
    push_o.res[1].edge_res = edge_b;
    push_o.res[2].out_col  = ledt_pkg::OutColW'(ctrl_i.x);
    push_o.res[2].out_row  = row_prev;
    push_o.res[2].edge_res = edge_c;
    push_o.res[3].out_col  = ledt_pkg::OutColW'(ctrl_i.x);
    push_o.res[3].out_row  = ctrl_i.y;
    push_o.res[3].edge_res = edge_d;

    push_o.res[0].last_of_run = push_o.vld[0] & ~(|push_o.vld[3:1]);
    push_o.res[1].last_of_run = push_o.vld[1] & ~(|push_o.vld[3:2]);
    push_o.res[2].last_of_run = push_o.vld[2] & ~push_o.vld[3];
    push_o.res[3].last_of_run = push_o.vld[3];
  end

endmodule

`default_nettype wire

// ----- rtl/ledt_res_fifo.sv -----
`default_nettype none

module ledt_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ledt_pkg::push_t     push_i,
  output logic                level_high_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ledt_pkg::res_t      out_word_o
);

  ledt_pkg::res_t                  mem_q [ledt_pkg::FifoDepth];
  logic [ledt_pkg::FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ledt_pkg::FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ledt_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic [ledt_pkg::FifoPtrW-1:0]   idx [ledt_pkg::MaxRes];
  logic [ledt_pkg::FifoCntW-1:0]   n_push;
  logic                            pop;

  // packed write positions of the valid words
  always_comb begin
    logic [ledt_pkg::FifoPtrW-1:0] run;
    logic [ledt_pkg::FifoCntW-1:0] n;
    run = wr_ptr_q;
    n   = '0;
    for (int k = 0; k < ledt_pkg::MaxRes; k++) begin
      idx[k] = run;
      run    = run + ledt_pkg::FifoPtrW'(push_i.vld[k]);
      n      = n + ledt_pkg::FifoCntW'(push_i.vld[k]);
    end
    n_push = n;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ledt_pkg::MaxRes; k++) begin
      if (push_i.vld[k]) begin
        mem_q[idx[k]] <= push_i.res[k];
      end
    end
  end

  // pointers and fill level
  assign pop      = (cnt_q != '0) & ~out_stall_i;
  assign wr_ptr_d = wr_ptr_q + n_push[ledt_pkg::FifoPtrW-1:0];
  assign rd_ptr_d = rd_ptr_q + ledt_pkg::FifoPtrW'(pop);
  assign cnt_d    = cnt_q + n_push - ledt_pkg::FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o  = cnt_q != '0;
  assign out_word_o   = mem_q[rd_ptr_q];
  // room kept for the pixel in flight and the next one
  assign level_high_o = cnt_q > ledt_pkg::FifoCntW'(ledt_pkg::StallLevel);

endmodule

`default_nettype wire

// ----- bench/laplacian_edge_threshold_top_tb.sv -----
import ledt_pkg::*;

// predicts edge marks for each accepted pixel and checks every result word
class edge_board;
  logic [WidthW-1:0]   width_reg;
  logic [RowW-1:0]     height_reg;
  logic [ThrW-1:0]     thr_reg;
  logic [PixW-1:0]     row_older [MaxWidth];
  logic [PixW-1:0]     row_newer [MaxWidth];
  logic [PixW-1:0]     win [6];
  logic [PixW-1:0]     tap [9];
  int                  col_pos;
  int                  row_pos;
  res_t                marks_q [$];
  int                  errors;
  int                  pixels;
  int                  words;
  int                  edges;

  function new();
    width_reg  = 12'd640;
    height_reg = 16'd480;
    thr_reg    = 8'd128;
    foreach (row_older[i]) begin
      row_older[i] = '0;
      row_newer[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    errors  = 0;
    pixels  = 0;
    words   = 0;
    edges   = 0;
  endfunction

  function int pending();
    return marks_q.size();
  endfunction

  // register write; geometry restarts the frame
  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgImageWidth: begin
        width_reg = data[WidthW-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      CfgImageHeight: begin
        height_reg = data;
        col_pos = 0;
        row_pos = 0;
      end
      CfgEdgeThreshold: thr_reg = data[ThrW-1:0];
      default: ;
    endcase
  endfunction

  // rounded luma from q0.16 weights
  function logic [PixW-1:0] luma_of(pix_t p);
    logic [31:0] acc;
    acc = LumaR * p.red + LumaG * p.green + LumaB * p.blue + LumaRound;
    return acc[LumaShift +: PixW];
  endfunction

  // clamped cross laplacian on the 3x3 block of rows y-2..y, columns x-2..x
  function int laplace_at(int cx, int cy, int x, int y, int w, int h);
    int lc, rc, ur, dr, c0, r0, v;
    lc = (cx - 1 < 0) ? 0 : cx - 1;
    rc = (cx + 1 > w - 1) ? w - 1 : cx + 1;
    ur = (cy - 1 < 0) ? 0 : cy - 1;
    dr = (cy + 1 > h - 1) ? h - 1 : cy + 1;
    c0 = x - 2;
    r0 = y - 2;
    v = 4 * int'(tap[(cy - r0) * 3 + cx - c0])
        - int'(tap[(cy - r0) * 3 + lc - c0])
        - int'(tap[(cy - r0) * 3 + rc - c0])
        - int'(tap[(ur - r0) * 3 + cx - c0])
        - int'(tap[(dr - r0) * 3 + cx - c0]);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // one accepted pixel: queue the marks it releases, then advance the window
  function void note_pixel(pix_t p);
    int w, h, x, y, i, k, cy, v, ncols, n;
    int cols [2];
    logic [PixW-1:0] lum;
    res_t mark;
    w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
    h = (height_reg == 0) ? 1 : int'(height_reg);
    x = col_pos;
    y = row_pos;
    lum = luma_of(p);
    pixels++;
    for (k = 0; k < 3; k++) begin
      tap[k * 3]     = win[k * 2];
      tap[k * 3 + 1] = win[k * 2 + 1];
    end
    tap[2] = row_older[x];
    tap[5] = row_newer[x];
    tap[8] = lum;

    ncols = 0;
    if (x >= 1) begin
      cols[ncols] = x - 1;
      ncols++;
    end
    if (x == w - 1) begin
      cols[ncols] = x;
      ncols++;
    end

    n = 0;
    for (i = 0; i < ncols; i++) begin
      for (k = 0; k < 2; k++) begin
        cy = y - 1 + k;
        if ((k == 0 && y >= 1) || (k == 1 && y == h - 1)) begin
          v = laplace_at(cols[i], cy, x, y, w, h);
          mark.out_col     = OutColW'(cols[i]);
          mark.out_row     = RowW'(cy);
          mark.edge_res    = (v > int'(thr_reg));
          mark.last_of_run = 1'b0;
          marks_q.push_back(mark);
          n++;
        end
      end
    end
    // flag the final word of this pixel
    if (n > 0) begin
      mark = marks_q.pop_back();
      mark.last_of_run = 1'b1;
      marks_q.push_back(mark);
    end

    row_older[x] = tap[5];
    row_newer[x] = lum;
    for (k = 0; k < 3; k++) begin
      win[k * 2]     = tap[k * 3 + 1];
      win[k * 2 + 1] = tap[k * 3 + 2];
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare a result word with the oldest queued mark
  function void check_result(res_t got);
    res_t want;
    if (marks_q.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, actual col %0d row %0d edge %0b last %0b",
               $time, got.out_col, got.out_row, got.edge_res, got.last_of_run);
      return;
    end
    want = marks_q.pop_front();
    words++;
    if (got.edge_res) edges++;
    compare_field("out_col", want.out_col, got.out_col);
    compare_field("out_row", want.out_row, got.out_row);
    compare_field("edge_res", want.edge_res, got.edge_res);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module laplacian_edge_threshold_top_tb;
  localparam int IdlePct     = 26;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 8;
  localparam int RandPhases  = 8;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                pix_valid = 1'b0;
  pix_t                pix_word  = '0;
  logic                pix_stall;
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_t                res_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  edge_board board;
  pix_t      last_pix = '0;
  bit        steady   = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        cfg_writes = 0;
  int        quiet_cycles = 0;
  int        phase;

  laplacian_edge_threshold_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_stall_o  (pix_stall),
    .in_word_i   (pix_word),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_word_o  (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < IdlePct);
  endfunction

  function automatic pix_t rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    return '{red: r, green: g, blue: b};
  endfunction

  // random pixel: noise, a near copy of the last one, or saturated channels
  function automatic pix_t pick_pixel();
    pix_t p;
    case ($urandom_range(2))
      0: p = rgb(8'($urandom), 8'($urandom), 8'($urandom));
      1: p = rgb(last_pix.red ^ 8'($urandom_range(7)), last_pix.green ^ 8'($urandom_range(7)),
                 last_pix.blue ^ 8'($urandom_range(7)));
      default: p = rgb($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                       $urandom_range(1) ? 8'hFF : 8'h00);
    endcase
    last_pix = p;
    return p;
  endfunction

  // offer one pixel word and wait for it to be taken
  task automatic send_pixel(input pix_t p);
    while (take_break()) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_word  <= p;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    board.note_pixel(p);
  endtask

  // stop offering and wait for every queued mark, plus the pipeline tail
  task automatic drain();
    pix_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_pixels(input int count, input bit pause_mid);
    int i;
    for (i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) drain();
      send_pixel(pick_pixel());
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  // result side: check each accepted word, then choose the next stall
  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) board.check_result(res_word);
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= take_break();
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // reset geometry: the start of row 0 of a 640 wide frame releases nothing
    run_pixels(20, 1'b0);
    drain();

    // 3x3 frame of hand-picked colours, every pixel marked when above zero
    write_reg(CfgImageWidth, 16'd3, 1'b0);
    write_reg(CfgImageHeight, 16'd3, 1'b0);
    write_reg(CfgEdgeThreshold, 16'd0, 1'b1);
    send_pixel(rgb(8'h00, 8'h00, 8'h00));
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgb(8'hFF, 8'h00, 8'h00));
    send_pixel(rgb(8'h00, 8'hFF, 8'h00));
    send_pixel(rgb(8'h00, 8'h00, 8'hFF));
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgb(8'h00, 8'h00, 8'h00));
    send_pixel(rgb(8'h80, 8'h80, 8'h80));
    send_pixel(rgb(8'hFF, 8'hFF, 8'h00));
    drain();

    // checkerboard: saturated sums clamp to 255, negative ones to 0
    write_reg(CfgEdgeThreshold, 16'd254, 1'b1);
    for (phase = 0; phase < 9; phase++)
      send_pixel(phase % 2 == 0 ? rgb(8'hFF, 8'hFF, 8'hFF) : rgb(8'h00, 8'h00, 8'h00));
    drain();

    // zero geometry acts as a single pixel frame
    write_reg(CfgImageWidth, 16'h0000, 1'b0);
    write_reg(CfgImageHeight, 16'h0000, 1'b0);
    write_reg(CfgEdgeThreshold, 16'hFF05, 1'b1);
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgb(8'h00, 8'h00, 8'h00));
    drain();

    // write to the spare index must change nothing
    write_reg(CfgSpare, 16'hFFFF, 1'b1);
    send_pixel(rgb(8'h12, 8'hED, 8'h5A));
    drain();

    // oversized width clamps to the full line store, one row frame, no idling
    write_reg(CfgImageWidth, 16'hFFFF, 1'b0);
    write_reg(CfgImageHeight, 16'h0000, 1'b0);
    write_reg(CfgEdgeThreshold, 16'h0080, 1'b1);
    steady = 1'b1;
    run_pixels(40, 1'b0);
    drain();
    steady = 1'b0;

    // tallest frame, one pixel per row
    write_reg(CfgImageWidth, 16'd1, 1'b0);
    write_reg(CfgImageHeight, 16'hFFFF, 1'b1);
    run_pixels(24, 1'b0);
    drain();

    // random small geometries; some phases only move the threshold mid-frame
    for (phase = 0; phase < RandPhases; phase++) begin
      if (phase % 3 != 2) begin
        write_reg(CfgImageWidth, {4'($urandom), 12'($urandom_range(1, 9))}, 1'b0);
        write_reg(CfgImageHeight, 16'($urandom_range(1, 6)), 1'b0);
      end
      write_reg(CfgEdgeThreshold,
                {8'($urandom), phase == 0 ? 8'd0 : phase == 1 ? 8'd255 : 8'($urandom)}, 1'b1);
      // long output hold against a sender that never idles
      if (phase == 2) begin
        steady   = 1'b1;
        hold_req = 1'b1;
      end
      run_pixels($urandom_range(28, 40), phase == 5);
      drain();
      steady = 1'b0;
    end

    // let any stray word show up
    while (board.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Checked %0d result words (%0d edges) from %0d pixels after %0d register writes.",
             board.words, board.edges, board.pixels, cfg_writes);
    $display("Frames from 1x1 to 9x6, a clamped oversized width and a one column tall frame,");
    $display("thresholds 0 to 255, random idling and a long output hold that fills the block.");
    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
